FILE: src/pole_pkg.sv
// Shared types and constants for the positional ordered list engine.
// No dependencies; imported by every module of the block.
package pole_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 2;
    localparam int SCAN_CHUNK      = 8;   // match bits examined per scan cycle

    localparam int OP_W     = 3;
    localparam int IN_VAL_W = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;
    localparam int FIDX_W   = 5;
    localparam int LEN_W    = 5;

    localparam logic [FIDX_W-1:0] FOUND_NONE = '1;   // -1

    typedef enum logic [OP_W-1:0] {
        OP_ADD_FRONT    = 3'd0,
        OP_ADD_BACK     = 3'd1,
        OP_INSERT_AT    = 3'd2,
        OP_REMOVE_FRONT = 3'd3,
        OP_REMOVE_BACK  = 3'd4,
        OP_REMOVE_AT    = 3'd5,
        OP_UPDATE       = 3'd6,
        OP_SEARCH       = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_SEARCH = 2'd3
    } kind_t;

    // Classified request; pos is only consulted when neither end flag is set
    typedef struct packed {
        kind_t                   kind;
        logic                    at_front;
        logic                    at_back;
        logic signed [POS_W-1:0] pos;
    } req_ctrl_t;

endpackage

FILE: src/pole_front.sv
// Front end: classifies a request and sizes its word to the store width.
// Depends on pole_pkg.
module pole_front import pole_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic [OP_W-1:0]            operation,
    input  logic signed [IN_VAL_W-1:0] value,
    input  logic signed [POS_W-1:0]    position,
    output req_ctrl_t                  ctrl,
    output logic [VALUE_WIDTH-1:0]     word
);

    // sign-extends or truncates as the store width needs
    assign word = VALUE_WIDTH'(value);

    always_comb
    begin
        ctrl.kind     = KIND_SEARCH;
        ctrl.at_front = 1'b0;
        ctrl.at_back  = 1'b0;
        ctrl.pos      = position;
        unique case (op_t'(operation))
            OP_ADD_FRONT:
            begin
                ctrl.kind     = KIND_INSERT;
                ctrl.at_front = 1'b1;
            end
            OP_ADD_BACK:
            begin
                ctrl.kind    = KIND_INSERT;
                ctrl.at_back = 1'b1;
            end
            OP_INSERT_AT:
            begin
                ctrl.kind     = KIND_INSERT;
                ctrl.at_front = (position == '0);
                ctrl.at_back  = position[POS_W-1];
            end
            OP_REMOVE_FRONT:
            begin
                ctrl.kind     = KIND_REMOVE;
                ctrl.at_front = 1'b1;
            end
            OP_REMOVE_BACK:
            begin
                ctrl.kind    = KIND_REMOVE;
                ctrl.at_back = 1'b1;
            end
            OP_REMOVE_AT:
            begin
                ctrl.kind     = KIND_REMOVE;
                ctrl.at_front = (position == '0) || position[POS_W-1];
            end
            OP_UPDATE:
            begin
                ctrl.kind = KIND_UPDATE;
                if (position[POS_W-1])
                begin
                    ctrl.pos = '0;
                end
            end
            OP_SEARCH:
            begin
                ctrl.kind = KIND_SEARCH;
            end
            default:
            begin
                ctrl.kind = KIND_SEARCH;
            end
        endcase
    end

endmodule

FILE: src/pole_queue.sv
// Short request queue between front and back ends.
// Depends on pole_pkg for the default depth.
module pole_queue import pole_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/pole_back.sv
// Back end: register-cell list with shift insert/remove, parallel compare
// search scanned a chunk per cycle, and the result output register.
// Depends on pole_pkg.
module pole_back import pole_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  req_ctrl_t               head_ctrl,
    input  logic [VALUE_WIDTH-1:0]  head_word,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [FIDX_W-1:0]       found_index,
    output logic [LEN_W-1:0]        length
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW + 1 : POS_W + 1;
    localparam int NCH  = (CAPACITY + SCAN_CHUNK - 1) / SCAN_CHUNK;
    localparam int MW   = NCH * SCAN_CHUNK;
    localparam int CIW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SW   = $clog2(SCAN_CHUNK);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           cnt_next;
    logic [MW-1:0]           match_reg;
    logic [CIW-1:0]          chunk_reg;
    status_t                 res_status_reg;
    logic [FIDX_W-1:0]       res_found_reg;
    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [FIDX_W-1:0]       out_found_reg;
    logic [LEN_W-1:0]        out_len_reg;

    logic [VALUE_WIDTH-1:0]  entries_reg [CAPACITY];
    logic [VALUE_WIDTH-1:0]  prev_word [CAPACITY];
    logic [VALUE_WIDTH-1:0]  next_word [CAPACITY];
    logic [MW-1:0]           match_vec;

    logic                    go;
    logic                    do_ins;
    logic                    do_rem;
    logic                    do_upd;
    logic                    ins_en;
    logic                    rem_en;
    logic                    upd_en;
    logic [IW-1:0]           exec_idx;
    status_t                 exec_status;
    logic [CMPW-1:0]         pos_ext;
    logic [CMPW-1:0]         cnt_ext;

    logic [SCAN_CHUNK-1:0]   chunk_bits;
    logic                    chunk_hit;
    logic [SW-1:0]           chunk_sub;
    logic                    slot_free;

    assign go        = (state_reg == S_IDLE) && head_valid;
    assign pop       = go;
    assign ins_en    = go && do_ins;
    assign rem_en    = go && do_rem;
    assign upd_en    = go && do_upd;
    assign slot_free = !out_valid_reg || !out_stall;

    // position is non-negative whenever it is used
    assign pos_ext = CMPW'(unsigned'(head_ctrl.pos));
    assign cnt_ext = CMPW'(cnt_reg);

    always_comb
    begin
        exec_status = ST_OK;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        do_upd      = 1'b0;
        exec_idx    = '0;
        unique case (head_ctrl.kind)
            KIND_INSERT:
            begin
                if (cnt_reg == CW'(CAPACITY))
                begin
                    exec_status = ST_FULL;
                end
                else if (head_ctrl.at_front)
                begin
                    do_ins = 1'b1;
                end
                else if (head_ctrl.at_back)
                begin
                    do_ins   = 1'b1;
                    exec_idx = IW'(cnt_reg);
                end
                else if (pos_ext <= cnt_ext)
                begin
                    do_ins   = 1'b1;
                    exec_idx = IW'(pos_ext);
                end
                else
                begin
                    exec_status = ST_BADPOS;
                end
            end
            KIND_REMOVE:
            begin
                if (cnt_reg == '0)
                begin
                    exec_status = ST_EMPTY;
                end
                else if (head_ctrl.at_front)
                begin
                    do_rem = 1'b1;
                end
                else if (head_ctrl.at_back)
                begin
                    do_rem   = 1'b1;
                    exec_idx = IW'(cnt_reg - 1'b1);
                end
                else if (pos_ext < cnt_ext)
                begin
                    do_rem   = 1'b1;
                    exec_idx = IW'(pos_ext);
                end
                else
                begin
                    exec_status = ST_BADPOS;
                end
            end
            KIND_UPDATE:
            begin
                if (pos_ext < cnt_ext)
                begin
                    do_upd   = 1'b1;
                    exec_idx = IW'(pos_ext);
                end
                else
                begin
                    exec_status = ST_BADPOS;
                end
            end
            KIND_SEARCH:
            begin
                exec_status = ST_NOTFOUND;
            end
            default:
            begin
                exec_status = ST_NOTFOUND;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ins_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rem_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // list cells: each holds its word or takes the new word, its left neighbor or its right one
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        localparam logic [IW-1:0] KI = IW'(k);

        if (k == 0)
        begin : g_first
            assign prev_word[k] = head_word;
        end
        else
        begin : g_mid
            assign prev_word[k] = entries_reg[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign next_word[k] = entries_reg[k];
        end
        else
        begin : g_inner
            assign next_word[k] = entries_reg[k+1];
        end

        assign match_vec[k] = (entries_reg[k] == head_word) && (CW'(k) < cnt_reg);

        always_ff @(posedge clk)
        begin
            if ((ins_en || upd_en) && (KI == exec_idx))
            begin
                entries_reg[k] <= head_word;
            end
            else if (ins_en && (KI > exec_idx))
            begin
                entries_reg[k] <= prev_word[k];
            end
            else if (rem_en && (KI >= exec_idx))
            begin
                entries_reg[k] <= next_word[k];
            end
        end
    end

    if (MW > CAPACITY)
    begin : g_pad
        assign match_vec[MW-1:CAPACITY] = '0;
    end

    always_comb
    begin
        chunk_bits = match_reg[{chunk_reg, {SW{1'b0}}} +: SCAN_CHUNK];
        chunk_hit  = 1'b0;
        chunk_sub  = '0;
        for (int j = SCAN_CHUNK - 1; j >= 0; j--)
        begin
            if (chunk_bits[j])
            begin
                chunk_hit = 1'b1;
                chunk_sub = SW'(j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            match_reg      <= '0;
            chunk_reg      <= '0;
            res_status_reg <= ST_OK;
            res_found_reg  <= FOUND_NONE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_found_reg  <= FOUND_NONE;
            out_len_reg    <= '0;
        end
        else
        begin
            if ((state_reg == S_EMIT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        cnt_reg        <= cnt_next;
                        res_status_reg <= exec_status;
                        res_found_reg  <= FOUND_NONE;
                        if (head_ctrl.kind == KIND_SEARCH)
                        begin
                            match_reg <= match_vec;
                            chunk_reg <= '0;
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (chunk_hit)
                    begin
                        res_status_reg <= ST_OK;
                        res_found_reg  <= FIDX_W'({chunk_reg, chunk_sub});
                        state_reg      <= S_EMIT;
                    end
                    else if (chunk_reg == CIW'(NCH - 1))
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        chunk_reg <= chunk_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_status_reg <= res_status_reg;
                        out_found_reg  <= res_found_reg;
                        out_len_reg    <= LEN_W'(cnt_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_index = out_found_reg;
    assign length      = out_len_reg;

endmodule

FILE: src/positional_ordered_list_engine.sv
// Top level of the positional ordered list engine: front classifier, request
// queue and list back end. Depends on pole_pkg, pole_front, pole_queue, pole_back.
//
//  channel  handshake              payload
//  -------  ---------------------  ----------------------------------
//  input    in_valid / in_stall    operation, value, position
//  output   out_valid / out_stall  status, found_index, length
//
// Add, remove and update execute on the register cells in the back end, then
// load the output register, which waits while the output is stalled. Search
// first scans the match vector, 8 cells a cycle, up to the first hit.
// A two-entry queue lets requests be accepted while the back end works.
// Reset clears the list length, queue and output valid; no clearing pass.
// in_stall rises only when the queue is full; a stalled result holds.
module positional_ordered_list_engine import pole_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OP_W-1:0]            operation,
    input  logic signed [IN_VAL_W-1:0] value,
    input  logic signed [POS_W-1:0]    position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic signed [FIDX_W-1:0]   found_index,
    output logic [LEN_W-1:0]           length
);

    localparam int QW = $bits(req_ctrl_t) + VALUE_WIDTH;

    req_ctrl_t              fe_ctrl;
    logic [VALUE_WIDTH-1:0] fe_word;
    logic [QW-1:0]          q_rd_data;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    req_ctrl_t              be_ctrl;
    logic [VALUE_WIDTH-1:0] be_word;
    logic [FIDX_W-1:0]      be_found;

    pole_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .operation (operation),
        .value     (value),
        .position  (position),
        .ctrl      (fe_ctrl),
        .word      (fe_word)
    );

    pole_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (in_valid),
        .wr_data ({fe_ctrl, fe_word}),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign in_stall = q_full;
    assign be_ctrl  = req_ctrl_t'(q_rd_data[QW-1:VALUE_WIDTH]);
    assign be_word  = q_rd_data[VALUE_WIDTH-1:0];

    pole_back #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (!q_empty),
        .head_ctrl   (be_ctrl),
        .head_word   (be_word),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_index (be_found),
        .length      (length)
    );

    assign found_index = be_found;

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end popped an empty queue");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (be_found != FOUND_NONE)) |-> (status == ST_OK))
        else $error("found index without ok status");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (length == LEN_W'(CAPACITY)))
        else $error("full status with list not at capacity");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |-> (length == '0))
        else $error("empty status with nonzero length");
`endif

endmodule
